### hw/rtl/jefs_pkg.sv
package jefs_pkg;

   // Marker codes recognised while scanning for the start of the payload.
   localparam logic [7:0] MK_FILL  = 8'hFF;
   localparam logic [7:0] MK_SOI   = 8'hD8;
   localparam logic [7:0] MK_APP0  = 8'hE0;
   localparam logic [7:0] MK_APP1  = 8'hE1;
   localparam logic [7:0] MK_APP13 = 8'hED;
   localparam logic [7:0] MK_COM   = 8'hFE;

   // Bytes of the length field that count towards a segment length.
   localparam logic [15:0] LEN_FIELD_BYTES = 16'd2;

   // Phase codes reported with every result.
   localparam logic [1:0] PHASE_SCAN    = 2'd0;
   localparam logic [1:0] PHASE_COLLECT = 2'd1;
   localparam logic [1:0] PHASE_DONE    = 2'd2;
   localparam logic [1:0] PHASE_FAILED  = 2'd3;

   // Scanner states, one-hot.
   typedef enum logic [6:0] {
      ST_SCAN    = 7'b0000001,
      ST_LEN_HI  = 7'b0000010,
      ST_LEN_LO  = 7'b0000100,
      ST_SKIP    = 7'b0001000,
      ST_COLLECT = 7'b0010000,
      ST_FAILED  = 7'b0100000,
      ST_DONE    = 7'b1000000
   } state_type;

   // One result transaction.
   typedef struct packed {
      logic        data_valid;
      logic [7:0]  data_byte;
      logic [15:0] data_index;
      logic [15:0] payload_length;
      logic        payload_last;
      logic [1:0]  phase;
   } result_type;

endpackage

### hw/rtl/jefs_scan.sv
module jefs_scan (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               mode,
   input  logic [7:0]         byte_value,
   output jefs_pkg::result_type result
);
   import jefs_pkg::*;

   state_type   state_ff, state_in;
   logic [15:0] seg_len_ff, seg_len_in;
   logic        skip_ff, skip_in;
   logic [15:0] copied_ff, copied_in;

   logic [15:0] len_full;
   logic [15:0] copied_next;
   logic [15:0] skip_left;

   assign len_full    = seg_len_ff | {8'h00, byte_value};
   assign copied_next = copied_ff + 16'd1;
   assign skip_left   = seg_len_ff - 16'd1;

   // Next state and result for the byte on offer.
   always_comb begin
      state_in   = state_ff;
      seg_len_in = seg_len_ff;
      skip_in    = skip_ff;
      copied_in  = copied_ff;
      result     = '0;

      if (mode) begin
         state_in   = ST_SCAN;
         seg_len_in = '0;
         skip_in    = 1'b0;
         copied_in  = '0;
      end else begin
         case (state_ff)
            ST_SCAN: begin
               if (byte_value == MK_FILL || byte_value == MK_SOI) begin
                  state_in = ST_SCAN;
               end else if (byte_value == MK_APP0 || byte_value == MK_APP13 ||
                            byte_value == MK_COM) begin
                  skip_in  = 1'b1;
                  state_in = ST_LEN_HI;
               end else if (byte_value == MK_APP1) begin
                  skip_in  = 1'b0;
                  state_in = ST_LEN_HI;
               end else begin
                  // Raw EXIF: this byte already is the length high byte.
                  skip_in    = 1'b0;
                  seg_len_in = {byte_value, 8'h00};
                  state_in   = ST_LEN_LO;
               end
            end
            ST_LEN_HI: begin
               seg_len_in = {byte_value, 8'h00};
               state_in   = ST_LEN_LO;
            end
            ST_LEN_LO: begin
               skip_in = 1'b0;
               if (skip_ff) begin
                  // A short skip length skips nothing.
                  if (len_full <= LEN_FIELD_BYTES) begin
                     seg_len_in = '0;
                     state_in   = ST_SCAN;
                  end else begin
                     seg_len_in = len_full - LEN_FIELD_BYTES;
                     state_in   = ST_SKIP;
                  end
               end else if (len_full == 16'd0) begin
                  seg_len_in = len_full;
                  state_in   = ST_FAILED;
               end else begin
                  seg_len_in = len_full;
                  copied_in  = '0;
                  state_in   = ST_COLLECT;
               end
            end
            ST_SKIP: begin
               seg_len_in = skip_left;
               if (skip_left == 16'd0) begin
                  state_in = ST_SCAN;
               end
            end
            ST_COLLECT: begin
               result.data_valid = 1'b1;
               result.data_byte  = byte_value;
               result.data_index = copied_ff;
               copied_in         = copied_next;
               if (copied_next == seg_len_ff) begin
                  result.payload_last = 1'b1;
                  state_in            = ST_DONE;
               end
            end
            ST_FAILED, ST_DONE: begin
               state_in = state_ff;
            end
            default: begin
               state_in   = ST_SCAN;
               seg_len_in = '0;
               skip_in    = 1'b0;
               copied_in  = '0;
            end
         endcase

         // Length and phase follow the state after this byte.
         case (state_in)
            ST_COLLECT: begin
               result.phase          = PHASE_COLLECT;
               result.payload_length = seg_len_in;
            end
            ST_DONE: begin
               result.phase          = PHASE_DONE;
               result.payload_length = seg_len_in;
            end
            ST_FAILED: begin
               result.phase = PHASE_FAILED;
            end
            default: begin
               result.phase = PHASE_SCAN;
            end
         endcase
      end
   end

   // Scanner state advances on each accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_SCAN;
         seg_len_ff <= '0;
         skip_ff    <= 1'b0;
         copied_ff  <= '0;
      end else if (accept) begin
         state_ff   <= state_in;
         seg_len_ff <= seg_len_in;
         skip_ff    <= skip_in;
         copied_ff  <= copied_in;
      end
   end

`ifndef SYNTHESIS
   a_last_is_payload: assert property (@(posedge clock) disable iff (reset)
      accept && result.payload_last |-> result.data_valid && result.phase == PHASE_DONE)
      else $error("last flag without a final payload byte");

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      accept && !mode && state_ff == ST_COLLECT |=> copied_ff == $past(copied_ff) + 16'd1)
      else $error("payload counter did not advance by one");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      accept && !mode && (state_ff == ST_DONE || state_ff == ST_FAILED)
      |=> state_ff == $past(state_ff))
      else $error("terminal state left without restart");

   a_valid_in_payload: assert property (@(posedge clock) disable iff (reset)
      accept && result.data_valid
      |-> result.phase == PHASE_COLLECT || result.phase == PHASE_DONE)
      else $error("payload byte outside the payload phases");
`endif

endmodule

### hw/rtl/jefs_out_reg.sv
module jefs_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  jefs_pkg::result_type in_result,
   output logic                 out_valid,
   input  logic                 out_ready,
   output jefs_pkg::result_type out_result
);
   import jefs_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff;

   // The register takes a new result whenever it is empty or being drained.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_valid || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         result_ff <= in_result;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

### hw/rtl/jpeg_exif_segment_finder.sv
// A result is registered and appears on the rsp_ side in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the rsp_ side is ready; the scanner state register
// is updated once per accepted byte and a result register decouples the two sides.
// Reset (synchronous, active high) returns the scanner to marker search and
// empties the result register; a restart byte (tuser high) does the same to the state.
module jpeg_exif_segment_finder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic        req_tuser,   // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] data_byte, [23:8] data_index,
                                    // [39:24] payload_length
   output logic [2:0]  rsp_tuser,   // [0] data_valid, [2:1] phase
   output logic        rsp_tlast    // payload_last
);
   import jefs_pkg::*;

   logic       accept;
   result_type scan_result;
   result_type out_result;

   assign accept = req_tvalid && req_tready;

   jefs_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .mode       (req_tuser),
      .byte_value (req_tdata),
      .result     (scan_result)
   );

   jefs_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_result  (scan_result),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (out_result)
   );

   // Pack the result transaction onto the stream fields.
   assign rsp_tdata = {out_result.payload_length, out_result.data_index,
                       out_result.data_byte};
   assign rsp_tuser = {out_result.phase, out_result.data_valid};
   assign rsp_tlast = out_result.payload_last;

endmodule
